// File: design/ecfms_pkg.sv
package ecfms_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_START_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_STOP_LIMIT   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIMULATE_ENABLE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIM_AUTO_SELECTOR = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIM_RUN_FEEDBACK  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIM_TRIP_FEEDBACK = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYPASS_INTERLOCK  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASSIGNED_PRIORITY = 3'd7;

   localparam logic [15:0] LIMIT_RESET        = 16'd120;
   localparam logic [6:0]  PRIORITY_IDLE      = 7'd99;
   localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
   localparam logic [5:0]  MINUTES_PER_HOUR   = 6'd60;

   localparam logic [2:0] STATE_STOP       = 3'd0;
   localparam logic [2:0] STATE_RUN        = 3'd1;
   localparam logic [2:0] STATE_MAINT      = 3'd3;
   localparam logic [2:0] STATE_TRIP       = 3'd4;
   localparam logic [2:0] STATE_FAIL_START = 3'd5;
   localparam logic [2:0] STATE_FAIL_STOP  = 3'd6;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_AUTO   = 2'd2,
      MODE_MAINT  = 2'd3
   } mode_type;

   typedef struct packed {
      logic       auto_selector;
      logic       run_feedback;
      logic       trip_feedback;
      logic       interlock_ok;
      logic       auto_start;
      logic       second_pulse;
      logic       reset_request;
      logic       mode_write;
      logic [1:0] mode_value;
   } req_type;

   typedef struct packed {
      logic        start_command;
      logic        permissive;
      logic        fault_active;
      logic        available;
      logic        running;
      logic [6:0]  priority_out;
      logic [2:0]  state_code;
      logic        fail_to_start;
      logic        fail_to_stop;
      logic [15:0] start_time;
      logic [15:0] stop_time;
      logic [31:0] run_hours;
   } rsp_type;

endpackage

// File: design/ec_fan_motor_supervisor.sv
// The result beat of an accepted scan is held in a registered result stage.
// Throughput: one scan per cycle; the next scan is taken while a result beat
// waits, as long as the result register is empty or being drained.
// The whole scan is evaluated in one pass of logic from the state registers.
// Reset (synchronous, active high) clears all scan state and the result valid flag,
// and returns every configuration register to its default; the result payload is not reset.
module ec_fan_motor_supervisor
   import ecfms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration
   logic [15:0] fail_start_limit_ff;
   logic [15:0] fail_stop_limit_ff;
   logic        simulate_enable_ff;
   logic        sim_auto_selector_ff;
   logic        sim_run_feedback_ff;
   logic        sim_trip_feedback_ff;
   logic        bypass_interlock_ff;
   logic [6:0]  assigned_priority_ff;

   // scan state
   mode_type    operator_mode_ff, operator_mode_in;
   mode_type    effective_mode_ff, effective_mode_in;
   logic        fault_latch_ff, fault_latch_in;
   logic [2:0]  state_reg_ff, state_reg_in;
   logic        start_fail_ff, start_fail_in;
   logic        stop_fail_ff, stop_fail_in;
   logic [15:0] start_counter_ff, start_counter_in;
   logic [15:0] stop_counter_ff, stop_counter_in;
   logic [5:0]  second_count_ff, second_count_in;
   logic [5:0]  minute_count_ff, minute_count_in;
   logic [31:0] hour_total_ff, hour_total_in;
   logic        previous_command_ff;
   logic        previous_run_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      logic        sel;
      logic        run;
      logic        trip;
      logic        ilk;
      logic        clear;
      logic        perm;
      logic        avail;
      logic [6:0]  prio;
      logic        cmd;
      logic        rise_cmd;
      logic        fall_cmd;
      logic        fall_run;
      logic [15:0] cnt;
      logic [5:0]  sec_sum;
      logic [5:0]  min_sum;
      mode_type    mode;

      if (simulate_enable_ff) begin
         sel  = sim_auto_selector_ff;
         run  = sim_run_feedback_ff;
         trip = sim_trip_feedback_ff;
      end else begin
         sel  = req_data.auto_selector;
         run  = req_data.run_feedback;
         trip = req_data.trip_feedback;
      end
      if (effective_mode_ff == MODE_MAINT) begin
         trip = 1'b0;
      end
      ilk = bypass_interlock_ff || req_data.interlock_ok;

      operator_mode_in = req_data.mode_write ? mode_type'(req_data.mode_value)
                                             : operator_mode_ff;
      mode             = operator_mode_in;
      fault_latch_in   = fault_latch_ff;
      state_reg_in     = state_reg_ff;
      start_fail_in    = start_fail_ff;
      stop_fail_in     = stop_fail_ff;
      start_counter_in = start_counter_ff;
      stop_counter_in  = stop_counter_ff;

      // alarm latch
      if (trip && mode != MODE_MAINT) begin
         fault_latch_in = 1'b1;
         state_reg_in   = STATE_TRIP;
         mode           = MODE_OFF;
      end else if (start_fail_ff) begin
         fault_latch_in = 1'b1;
         state_reg_in   = STATE_FAIL_START;
         mode           = MODE_OFF;
      end else if (stop_fail_ff) begin
         fault_latch_in = 1'b1;
         state_reg_in   = STATE_FAIL_STOP;
         mode           = MODE_OFF;
      end

      clear = req_data.reset_request && !trip;
      if (clear) begin
         fault_latch_in   = 1'b0;
         state_reg_in     = STATE_STOP;
         start_counter_in = '0;
         stop_counter_in  = '0;
         start_fail_in    = 1'b0;
         stop_fail_in     = 1'b0;
         if (operator_mode_in == MODE_MANUAL) begin
            operator_mode_in = MODE_OFF;
         end
      end

      // permissive
      perm  = 1'b0;
      avail = 1'b0;
      prio  = PRIORITY_IDLE;
      if (fault_latch_in) begin
         perm = 1'b0;
      end else if (mode == MODE_MAINT) begin
         state_reg_in = STATE_MAINT;
      end else begin
         if (sel) begin
            avail = (mode == MODE_AUTO);
            prio  = avail ? assigned_priority_ff : PRIORITY_IDLE;
            perm  = ilk;
         end
         state_reg_in = run ? STATE_RUN : STATE_STOP;
      end

      cmd = perm && ((mode == MODE_AUTO && req_data.auto_start) || mode == MODE_MANUAL);

      // supervision timers
      fall_run = previous_run_ff && !run;
      rise_cmd = cmd && !previous_command_ff;
      fall_cmd = !cmd && previous_command_ff;
      cnt      = '0;
      if (sel && mode != MODE_MAINT) begin
         if (cmd && !run) begin
            cnt = (rise_cmd || fall_run) ? 16'd0 : start_counter_in;
            if (req_data.second_pulse && cnt != 16'hFFFF) begin
               cnt = cnt + 16'd1;
            end
            start_counter_in = cnt;
            start_fail_in    = cnt > fail_start_limit_ff;
         end else if (!cmd && run) begin
            cnt = fall_cmd ? 16'd0 : stop_counter_in;
            if (req_data.second_pulse && cnt != 16'hFFFF) begin
               cnt = cnt + 16'd1;
            end
            stop_counter_in = cnt;
            stop_fail_in    = cnt > fail_stop_limit_ff;
         end
      end else if (!fault_latch_in) begin
         state_reg_in = run ? STATE_RUN : STATE_STOP;
      end

      // run hour totalizer
      second_count_in = second_count_ff;
      minute_count_in = minute_count_ff;
      hour_total_in   = hour_total_ff;
      sec_sum         = second_count_ff + 6'd1;
      min_sum         = minute_count_ff;
      if (req_data.second_pulse && run) begin
         if (sec_sum >= SECONDS_PER_MINUTE) begin
            min_sum         = minute_count_ff + 6'd1;
            second_count_in = '0;
         end else begin
            second_count_in = sec_sum;
         end
         if (min_sum >= MINUTES_PER_HOUR) begin
            if (hour_total_ff != 32'hFFFF_FFFF) begin
               hour_total_in = hour_total_ff + 32'd1;
            end
            minute_count_in = '0;
         end else begin
            minute_count_in = min_sum;
         end
      end

      effective_mode_in = mode;

      rsp_data_in.start_command = cmd;
      rsp_data_in.permissive    = perm;
      rsp_data_in.fault_active  = fault_latch_in;
      rsp_data_in.available     = avail;
      rsp_data_in.running       = run;
      rsp_data_in.priority_out  = prio;
      rsp_data_in.state_code    = state_reg_in;
      rsp_data_in.fail_to_start = start_fail_in;
      rsp_data_in.fail_to_stop  = stop_fail_in;
      rsp_data_in.start_time    = start_counter_in;
      rsp_data_in.stop_time     = stop_counter_in;
      rsp_data_in.run_hours     = hour_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_start_limit_ff  <= LIMIT_RESET;
         fail_stop_limit_ff   <= LIMIT_RESET;
         simulate_enable_ff   <= 1'b0;
         sim_auto_selector_ff <= 1'b0;
         sim_run_feedback_ff  <= 1'b0;
         sim_trip_feedback_ff <= 1'b0;
         bypass_interlock_ff  <= 1'b0;
         assigned_priority_ff <= PRIORITY_IDLE;
         operator_mode_ff     <= MODE_OFF;
         effective_mode_ff    <= MODE_OFF;
         fault_latch_ff       <= 1'b0;
         state_reg_ff         <= STATE_STOP;
         start_fail_ff        <= 1'b0;
         stop_fail_ff         <= 1'b0;
         start_counter_ff     <= '0;
         stop_counter_ff      <= '0;
         second_count_ff      <= '0;
         minute_count_ff      <= '0;
         hour_total_ff        <= '0;
         previous_command_ff  <= 1'b0;
         previous_run_ff      <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FAIL_START_LIMIT: begin
                  fail_start_limit_ff <= csr_wdata[15:0];
               end
               CSR_FAIL_STOP_LIMIT: begin
                  fail_stop_limit_ff <= csr_wdata[15:0];
               end
               CSR_SIMULATE_ENABLE: begin
                  simulate_enable_ff <= csr_wdata[0];
               end
               CSR_SIM_AUTO_SELECTOR: begin
                  sim_auto_selector_ff <= csr_wdata[0];
               end
               CSR_SIM_RUN_FEEDBACK: begin
                  sim_run_feedback_ff <= csr_wdata[0];
               end
               CSR_SIM_TRIP_FEEDBACK: begin
                  sim_trip_feedback_ff <= csr_wdata[0];
               end
               CSR_BYPASS_INTERLOCK: begin
                  bypass_interlock_ff <= csr_wdata[0];
               end
               CSR_ASSIGNED_PRIORITY: begin
                  assigned_priority_ff <= csr_wdata[6:0];
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            operator_mode_ff    <= operator_mode_in;
            effective_mode_ff   <= effective_mode_in;
            fault_latch_ff      <= fault_latch_in;
            state_reg_ff        <= state_reg_in;
            start_fail_ff       <= start_fail_in;
            stop_fail_ff        <= stop_fail_in;
            start_counter_ff    <= start_counter_in;
            stop_counter_ff     <= stop_counter_in;
            second_count_ff     <= second_count_in;
            minute_count_ff     <= minute_count_in;
            hour_total_ff       <= hour_total_in;
            previous_command_ff <= rsp_data_in.start_command;
            previous_run_ff     <= rsp_data_in.running;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // a latched fault always carries its cause in the state code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault_active |->
         (rsp_data.state_code == STATE_TRIP || rsp_data.state_code == STATE_FAIL_START ||
          rsp_data.state_code == STATE_FAIL_STOP))
      else $error("fault latched without a fault state code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_command |-> rsp_data.permissive)
      else $error("start command without permissive");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.available |-> rsp_data.priority_out == PRIORITY_IDLE)
      else $error("priority given while unavailable");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted scan produced no result beat");

   assert property (@(posedge clock) disable iff (reset)
      fault_latch_ff |-> !(rsp_valid_ff && rsp_data_ff.permissive && rsp_data_ff.fault_active))
      else $error("permissive granted with fault latched");
`endif

endmodule

// File: test/ec_fan_motor_supervisor_tb.sv
module ec_fan_motor_supervisor_tb;
   import ecfms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMER_SCANS   = 40;

   localparam rsp_type STATUS_CLEAR = rsp_type'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PRIORITY_IDLE,
      STATE_STOP, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0};
   localparam rsp_type STATUS_TRIPPED = rsp_type'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PRIORITY_IDLE,
      STATE_TRIP, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0};

   typedef struct packed {
      logic [15:0] start_limit;
      logic [15:0] stop_limit;
      logic        sim_en;
      logic        sim_sel;
      logic        sim_run;
      logic        sim_trip;
      logic        bypass;
      logic [6:0]  prio;
   } sup_cfg_t;

   typedef struct packed {
      mode_type    op_mode;
      mode_type    eff_mode;
      logic        fault;
      logic [2:0]  state;
      logic        cmd;
      logic        perm;
      logic        avail;
      logic [6:0]  prio;
      logic        start_fail;
      logic        stop_fail;
      logic [15:0] start_cnt;
      logic [15:0] stop_cnt;
      logic [5:0]  secs;
      logic [5:0]  mins;
      logic [31:0] hours;
      logic        prev_cmd;
      logic        prev_run;
      logic        run_eff;
   } sup_state_t;

   typedef struct {
      req_type scan;
      bit      typed;
      rsp_type want;
   } step_row_t;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_type                    rsp_data;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   sup_cfg_t   cfg;
   sup_state_t motor;
   rsp_type    pending_status[$];
   step_row_t  directed_rows[$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_left = 0;
   int  mismatch_count = 0;
   int  scans_sent = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   bit  plant_run = 1'b0;

   ec_fan_motor_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic req_type scan(bit sel, bit run, bit trip, bit ilk, bit ast, bit pulse,
                                    bit rst, bit mw, mode_type mv);
      req_type s;
      s = '{sel, run, trip, ilk, ast, pulse, rst, mw, mv};
      return s;
   endfunction

   function automatic rsp_type predict_scan(input req_type s);
      logic       sel, run, trip, ilk, fall_run, rise_cmd, fall_cmd;
      logic [2:0] cause;
      mode_type   mode;
      rsp_type    r;
      if (cfg.sim_en) begin
         sel = cfg.sim_sel;
         run = cfg.sim_run;
         trip = cfg.sim_trip;
      end else begin
         sel = s.auto_selector;
         run = s.run_feedback;
         trip = s.trip_feedback;
      end
      // trip masked while the last scan ran in maintenance
      if (motor.eff_mode == MODE_MAINT) begin
         trip = 1'b0;
         motor.prio = PRIORITY_IDLE;
         motor.avail = 1'b0;
      end
      ilk = cfg.bypass | s.interlock_ok;
      motor.run_eff = run;
      if (s.mode_write) motor.op_mode = mode_type'(s.mode_value);
      mode = motor.op_mode;

      cause = (trip && mode != MODE_MAINT) ? STATE_TRIP :
              motor.start_fail ? STATE_FAIL_START :
              motor.stop_fail ? STATE_FAIL_STOP : STATE_STOP;
      if (cause != STATE_STOP) begin
         motor.fault = 1'b1;
         motor.state = cause;
         mode = MODE_OFF;
         motor.prio = PRIORITY_IDLE;
         motor.avail = 1'b0;
      end
      if (s.reset_request && !trip) begin
         motor.fault = 1'b0;
         motor.state = STATE_STOP;
         motor.start_cnt = '0;
         motor.stop_cnt = '0;
         motor.start_fail = 1'b0;
         motor.stop_fail = 1'b0;
         if (motor.op_mode == MODE_MANUAL) motor.op_mode = MODE_OFF;
      end

      if (motor.fault) begin
         motor.perm = 1'b0;
         motor.avail = 1'b0;
         motor.prio = PRIORITY_IDLE;
      end else if (mode == MODE_MAINT) begin
         motor.state = STATE_MAINT;
         motor.perm = 1'b0;
         motor.avail = 1'b0;
         motor.prio = PRIORITY_IDLE;
      end else begin
         if (sel) begin
            motor.avail = (mode == MODE_AUTO);
            motor.prio = motor.avail ? cfg.prio : PRIORITY_IDLE;
            motor.perm = ilk;
         end else begin
            motor.perm = 1'b0;
            motor.avail = 1'b0;
            motor.prio = PRIORITY_IDLE;
         end
         motor.state = run ? STATE_RUN : STATE_STOP;
      end

      motor.cmd = motor.perm && ((mode == MODE_AUTO && s.auto_start) || mode == MODE_MANUAL);

      fall_run = motor.prev_run && !run;
      rise_cmd = motor.cmd && !motor.prev_cmd;
      fall_cmd = !motor.cmd && motor.prev_cmd;
      if (sel && mode != MODE_MAINT) begin
         if (motor.cmd && fall_run) motor.start_cnt = '0;
         if (motor.cmd && !run) begin
            if (rise_cmd) motor.start_cnt = '0;
            if (s.second_pulse && motor.start_cnt != 16'hFFFF)
               motor.start_cnt = motor.start_cnt + 16'd1;
            motor.start_fail = motor.start_cnt > cfg.start_limit;
         end else if (!motor.cmd && run) begin
            if (fall_cmd) motor.stop_cnt = '0;
            if (s.second_pulse && motor.stop_cnt != 16'hFFFF)
               motor.stop_cnt = motor.stop_cnt + 16'd1;
            motor.stop_fail = motor.stop_cnt > cfg.stop_limit;
         end
      end else if (!motor.fault) begin
         motor.state = run ? STATE_RUN : STATE_STOP;
      end

      if (s.second_pulse && run) begin
         motor.secs = motor.secs + 6'd1;
         if (motor.secs >= SECONDS_PER_MINUTE) begin
            motor.mins = motor.mins + 6'd1;
            motor.secs = '0;
         end
         if (motor.mins >= MINUTES_PER_HOUR) begin
            if (motor.hours != 32'hFFFF_FFFF) motor.hours = motor.hours + 32'd1;
            motor.mins = '0;
         end
      end

      motor.eff_mode = mode;
      motor.prev_cmd = motor.cmd;
      motor.prev_run = run;

      r.start_command = motor.cmd;
      r.permissive    = motor.perm;
      r.fault_active  = motor.fault;
      r.available     = motor.avail;
      r.running       = motor.run_eff;
      r.priority_out  = motor.prio;
      r.state_code    = motor.state;
      r.fail_to_start = motor.start_fail;
      r.fail_to_stop  = motor.stop_fail;
      r.start_time    = motor.start_cnt;
      r.stop_time     = motor.stop_cnt;
      r.run_hours     = motor.hours;
      return r;
   endfunction

   // field scan with a run feedback that holds for stretches; some pure noise
   function automatic req_type next_field_scan();
      req_type s;
      if ($urandom_range(9) == 0) plant_run = ~plant_run;
      s.auto_selector = ($urandom_range(9) != 0);
      s.run_feedback  = plant_run;
      s.trip_feedback = ($urandom_range(29) == 0);
      s.interlock_ok  = ($urandom_range(7) != 0);
      s.auto_start    = ($urandom_range(3) != 0);
      s.second_pulse  = 1'($urandom_range(1));
      s.reset_request = ($urandom_range(11) == 0);
      s.mode_write    = ($urandom_range(14) == 0);
      s.mode_value    = 2'($urandom_range(3));
      if ($urandom_range(9) == 0) s = req_type'(10'($urandom));
      return s;
   endfunction

   function automatic sup_cfg_t random_cfg();
      sup_cfg_t c;
      c.start_limit = 16'($urandom_range(6));
      c.stop_limit  = 16'($urandom_range(6));
      c.sim_en      = 1'b0;
      c.sim_sel     = 1'($urandom_range(1));
      c.sim_run     = 1'($urandom_range(1));
      c.sim_trip    = 1'($urandom_range(1));
      c.bypass      = 1'($urandom_range(1));
      c.prio        = 7'($urandom_range(127));
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("%0t ERROR %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("status beat with no scan pending");
         end else begin
            want = pending_status.pop_front();
            check_field("start_command", 32'(rsp_data.start_command),
                        32'(want.start_command));
            check_field("permissive", 32'(rsp_data.permissive), 32'(want.permissive));
            check_field("fault_active", 32'(rsp_data.fault_active), 32'(want.fault_active));
            check_field("available", 32'(rsp_data.available), 32'(want.available));
            check_field("running", 32'(rsp_data.running), 32'(want.running));
            check_field("priority_out", 32'(rsp_data.priority_out), 32'(want.priority_out));
            check_field("state_code", 32'(rsp_data.state_code), 32'(want.state_code));
            check_field("fail_to_start", 32'(rsp_data.fail_to_start),
                        32'(want.fail_to_start));
            check_field("fail_to_stop", 32'(rsp_data.fail_to_stop), 32'(want.fail_to_stop));
            check_field("start_time", 32'(rsp_data.start_time), 32'(want.start_time));
            check_field("stop_time", 32'(rsp_data.stop_time), 32'(want.stop_time));
            check_field("run_hours", rsp_data.run_hours, want.run_hours);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ec_fan_motor_supervisor verification failed");
         $finish;
      end
   end

   task automatic send_scan(input req_type s, input bit typed, input rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = predict_scan(s);
      pending_status.push_back(typed ? want : pred);
      scans_sent++;
   endtask

   task automatic send_field_scans(input int count);
      repeat (count) send_scan(next_field_scan(), 1'b0, STATUS_CLEAR);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value,
                          input int width);
      logic [15:0] keep;
      keep = 16'((32'd1 << width) - 1);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (value & keep) | (16'($urandom) & ~keep);
      @(posedge clock);
   endtask

   task automatic apply_config(input sup_cfg_t c);
      settle();
      csr_put(CSR_FAIL_START_LIMIT, c.start_limit, 16);
      csr_put(CSR_FAIL_STOP_LIMIT, c.stop_limit, 16);
      csr_put(CSR_SIMULATE_ENABLE, 16'(c.sim_en), 1);
      csr_put(CSR_SIM_AUTO_SELECTOR, 16'(c.sim_sel), 1);
      csr_put(CSR_SIM_RUN_FEEDBACK, 16'(c.sim_run), 1);
      csr_put(CSR_SIM_TRIP_FEEDBACK, 16'(c.sim_trip), 1);
      csr_put(CSR_BYPASS_INTERLOCK, 16'(c.bypass), 1);
      csr_put(CSR_ASSIGNED_PRIORITY, 16'(c.prio), 7);
      csr_write <= 1'b0;
      cfg = c;
      settings_used++;
   endtask

   task automatic add_row(input req_type s, input bit typed, input rsp_type want);
      step_row_t row;
      row.scan = s;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   initial begin
      sup_cfg_t c;
      req_type  s;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_FAIL_START_LIMIT;
      csr_wdata = '0;

      motor = '0;
      motor.prio = PRIORITY_IDLE;
      cfg = '0;
      cfg.start_limit = LIMIT_RESET;
      cfg.stop_limit = LIMIT_RESET;
      cfg.prio = PRIORITY_IDLE;

      //       sel run trp ilk ast pls rst mw  mode
      add_row(scan(0, 0, 0, 0, 0, 0, 0, 0, MODE_OFF),    1, STATUS_CLEAR);
      add_row(scan(1, 0, 1, 1, 0, 0, 0, 0, MODE_OFF),    1, STATUS_TRIPPED);
      add_row(scan(1, 0, 1, 1, 0, 0, 1, 0, MODE_OFF),    1, STATUS_TRIPPED);
      add_row(scan(1, 0, 0, 1, 0, 0, 1, 1, MODE_MANUAL), 0, STATUS_CLEAR);
      add_row(scan(1, 0, 0, 1, 0, 0, 0, 1, MODE_MANUAL), 0, STATUS_CLEAR);
      add_row(scan(1, 0, 0, 1, 0, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 1, 0, 1, 0, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 0, 0, 1, 0, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 1, 0, 0, 0, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 1, 0, 1, 1, 0, 0, 1, MODE_AUTO),   0, STATUS_CLEAR);
      add_row(scan(1, 1, 0, 1, 0, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 0, 1, 1, 0, 0, 0, 1, MODE_MAINT),  0, STATUS_CLEAR);
      add_row(scan(1, 0, 1, 1, 0, 0, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 0, 1, 1, 1, 0, 0, 1, MODE_AUTO),   0, STATUS_CLEAR);
      add_row(scan(1, 0, 1, 1, 1, 0, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 0, 0, 1, 1, 0, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 0, 0, 1, 1, 0, 1, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(1, 1, 1, 1, 1, 1, 1, 1, MODE_MAINT),  0, STATUS_CLEAR);
      add_row(scan(1, 1, 1, 1, 1, 1, 1, 1, MODE_MAINT),  0, STATUS_CLEAR);
      add_row(scan(0, 0, 0, 0, 0, 0, 0, 1, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(0, 1, 0, 1, 1, 1, 0, 1, MODE_AUTO),   0, STATUS_CLEAR);
      add_row(scan(1, 1, 0, 1, 1, 1, 0, 0, MODE_OFF),    0, STATUS_CLEAR);
      add_row(scan(0, 1, 1, 0, 1, 0, 0, 0, MODE_OFF),    0, STATUS_CLEAR);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_scan(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].want);

      // zero limits, priority 0, no idling
      c = random_cfg();
      c.start_limit = 16'd0;
      c.stop_limit = 16'd0;
      c.bypass = 1'b0;
      c.prio = 7'd0;
      apply_config(c);
      send_field_scans(200);

      send_idle_pct = 82;
      apply_config(random_cfg());
      send_field_scans(200);

      send_idle_pct = 0;
      stall_pct = 82;
      c = random_cfg();
      c.sim_en = 1'b1;
      c.prio = 7'd127;
      apply_config(c);
      send_field_scans(150);
      c = random_cfg();
      c.sim_en = 1'b1;
      c.sim_trip = 1'b0;
      c.sim_sel = 1'b1;
      apply_config(c);
      send_field_scans(150);

      // receiver holds off long enough to back up the input
      stall_pct = 0;
      apply_config(random_cfg());
      hold_left = 300;
      send_field_scans(120);
      settle();
      send_idle_pct = 37;
      stall_pct = 37;
      send_field_scans(200);

      send_idle_pct = 0;
      c = random_cfg();
      c.start_limit = 16'hFFFF;
      c.stop_limit = 16'hFFFF;
      c.bypass = 1'b1;
      c.prio = 7'd100;
      apply_config(c);
      send_field_scans(150);

      // start timer: manual, no run feedback, pulse every scan
      stall_pct = 0;
      c.sim_en = 1'b0;
      c.prio = PRIORITY_IDLE;
      apply_config(c);
      send_scan(scan(1, 0, 0, 1, 0, 0, 1, 0, MODE_OFF), 1'b0, STATUS_CLEAR);
      for (int i = 0; i < TIMER_SCANS; i++)
         send_scan(scan(1, 0, 0, 1, 0, 1, 0, i == 0, MODE_MANUAL), 1'b0, STATUS_CLEAR);

      // stop timer and run seconds from simulated running feedback
      c.sim_en = 1'b1;
      c.sim_sel = 1'b1;
      c.sim_run = 1'b1;
      c.sim_trip = 1'b0;
      c.bypass = 1'b0;
      apply_config(c);
      send_scan(scan(1, 0, 0, 1, 0, 0, 1, 1, MODE_OFF), 1'b0, STATUS_CLEAR);
      for (int i = 0; i < TIMER_SCANS; i++) begin
         s = req_type'(10'($urandom));
         s.second_pulse = 1'b1;
         s.reset_request = 1'b0;
         s.mode_write = 1'b0;
         send_scan(s, 1'b0, STATUS_CLEAR);
      end

      settle();
      $display("%0d scans over %0d csr settings: modes, faults, resets, simulation,",
               scans_sent, settings_used);
      $display("start and stop timer counting under idle and stall mixes");
      if (mismatch_count == 0) begin
         $display("ec_fan_motor_supervisor verification clean");
      end else begin
         $display("ec_fan_motor_supervisor verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/ecfms_pkg.sv
design/ec_fan_motor_supervisor.sv
test/ec_fan_motor_supervisor_tb.sv
